FILE: src/cpcc_pkg.sv
// Shared constants for the column pulse cluster centroid finder.
`default_nettype none
package cpcc_pkg;
  localparam int COLUMN_DEPTH  = 128;
  localparam int MAX_CLUSTERS  = 64;
  localparam int MIN_SPLIT_LEN = 4;

  localparam int SAMPLE_W   = 16;
  localparam int COORD_W    = 8;
  localparam int ENERGY_W   = 23;
  localparam int CENTROID_W = 15;

  localparam int IDX_W  = $clog2(COLUMN_DEPTH);
  localparam int CNT_W  = $clog2(COLUMN_DEPTH + 1);
  localparam int SEG_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int SADR_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  localparam int EACC_W = SAMPLE_W + IDX_W;
  localparam int WACC_W = SAMPLE_W + 2 * IDX_W;
  localparam int NUM_W  = WACC_W + 9;
  localparam int EXT_W  = EACC_W + ENERGY_W;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic [ENERGY_W-1:0]   ENERGY_MAX   = '1;
  localparam logic [CENTROID_W-1:0] CENTROID_MAX = '1;
endpackage
`default_nettype wire

FILE: src/cpcc_ram.sv
// Single write port, single registered read port RAM.
`default_nettype none
module cpcc_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  parameter int AW    = 7
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/cpcc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module cpcc_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [cpcc_pkg::NUM_W-1:0]  num,
  input  wire logic [cpcc_pkg::EACC_W-1:0] den,
  output logic                           done,
  output logic      [cpcc_pkg::NUM_W-1:0]  quo
);
  import cpcc_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [EACC_W-1:0] rem;
  logic [EACC_W-1:0] dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [EACC_W:0]   trial;
  logic              ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= '0;
        quo   <= num;
        dvs   <= den;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        rem   <= ge ? EACC_W'(trial - {1'b0, dvs}) : trial[EACC_W-1:0];
        quo   <= {quo[NUM_W-2:0], ge};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/column_pulse_cluster_centroid_top.sv
// Top level: column store, pulse scan and split sequencer, segment sums, result register.
// Samples are accepted while loading; the block is busy once the last sample arrives.
// The scan visits each stored sample in turn; a long pulse is split at valleys in a window.
// Each segment is summed, then divided by its energy; the divide is skipped if energy is zero.
// All work goes through the single read port of the column store and one shared divider.
// Reset (synchronous, rst high) clears threshold, counts and flags; store contents are kept.
`default_nettype none
module column_pulse_cluster_centroid_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [cpcc_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [cpcc_pkg::PDATA_W-1:0]       pwdata,
  output logic      [cpcc_pkg::PDATA_W-1:0]       prdata,
  output logic                                    pready,
  input  wire logic                               sample_valid,
  output logic                                    sample_stall,
  input  wire logic [cpcc_pkg::SAMPLE_W-1:0]      sample,
  input  wire logic [cpcc_pkg::COORD_W-1:0]       col_x,
  input  wire logic [cpcc_pkg::COORD_W-1:0]       col_y,
  input  wire logic                               last,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic      [cpcc_pkg::COORD_W-1:0]       out_x,
  output logic      [cpcc_pkg::COORD_W-1:0]       out_y,
  output logic      [cpcc_pkg::ENERGY_W-1:0]      cluster_energy,
  output logic      [cpcc_pkg::CENTROID_W-1:0]    centroid,
  output logic                                    overflow,
  output logic                                    last_cluster
);
  import cpcc_pkg::*;

  typedef enum logic [18:0] {
    S_LOAD       = 19'h00001,
    S_SCAN_INIT  = 19'h00002,
    S_SCAN_CUR   = 19'h00004,
    S_SCAN_NEXT  = 19'h00008,
    S_SCAN_EVAL  = 19'h00010,
    S_SCAN_END   = 19'h00020,
    S_SPLIT      = 19'h00040,
    S_WIN_RD     = 19'h00080,
    S_WIN_GET    = 19'h00100,
    S_VAL_EVAL   = 19'h00200,
    S_SPLIT_TAIL = 19'h00400,
    S_SEG_START  = 19'h00800,
    S_SEG_RD     = 19'h01000,
    S_SEG_GET    = 19'h02000,
    S_SUM_RD     = 19'h04000,
    S_SUM_ACC    = 19'h08000,
    S_DIV_START  = 19'h10000,
    S_DIV_WAIT   = 19'h20000,
    S_OUT        = 19'h40000
  } state_t;

  state_t state;

  logic [SAMPLE_W-1:0] threshold;
  logic [CNT_W-1:0]    count;
  logic [2*COORD_W-1:0] col_xy;
  logic                too_long;

  logic [CNT_W-1:0]    k;
  logic [SAMPLE_W-1:0] cur;
  logic                open;
  logic                scan_done;
  logic [IDX_W-1:0]    start;
  logic [IDX_W-1:0]    pa;
  logic [IDX_W-1:0]    pb;
  logic [IDX_W-1:0]    lo;
  logic [IDX_W-1:0]    wbase;
  logic [CNT_W-1:0]    sk;
  logic [2:0]          fill;
  logic [SAMPLE_W-1:0] win [5];

  logic [SEG_W-1:0]    seg_kept;
  logic                seg_over;
  logic [SEG_W-1:0]    seg_i;
  logic [IDX_W-1:0]    seg_hi;

  logic [EACC_W-1:0]   esum;
  logic [WACC_W-1:0]   wsum;

  logic                  cfg_we;
  logic                  in_xfer;
  logic                  out_xfer;
  logic [IDX_W-1:0]      rd_addr;
  logic [SAMPLE_W-1:0]   rdata;
  logic                  seg_add;
  logic [IDX_W-1:0]      seg_wlo;
  logic [IDX_W-1:0]      seg_whi;
  logic [2*IDX_W-1:0]    seg_rdata;
  logic                  seg_room;
  logic                  valley;
  logic                  opening;
  logic                  open_now;
  logic [IDX_W-1:0]      start_now;
  logic                  close;
  logic [IDX_W+SAMPLE_W-1:0] prod;
  logic [NUM_W-1:0]      numer;
  logic                  div_start;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quo;
  logic [EXT_W-1:0]      e_ext;
  logic                  last_seg;
  logic [IDX_W-1:0]      k_idx;
  logic [IDX_W-1:0]      k_inc;

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);
  assign prdata = (paddr[2] == REG_THRESHOLD) ? PDATA_W'(threshold) : '0;

  assign sample_stall = (state != S_LOAD);
  assign in_xfer      = sample_valid && !sample_stall;
  assign result_valid = (state == S_OUT);
  assign out_xfer     = result_valid && !result_stall;

  assign k_idx = k[IDX_W-1:0];
  assign k_inc = k_idx + IDX_W'(1);

  always_comb begin
    case (state)
      S_SCAN_INIT: rd_addr = k_idx;
      S_SCAN_NEXT: rd_addr = k_inc;
      S_WIN_RD:    rd_addr = sk[IDX_W-1:0];
      S_SUM_RD:    rd_addr = k_idx;
      default:     rd_addr = '0;
    endcase
  end

  cpcc_ram #(
    .DEPTH (COLUMN_DEPTH),
    .WIDTH (SAMPLE_W),
    .AW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (in_xfer && (count < CNT_W'(COLUMN_DEPTH))),
    .waddr (count[IDX_W-1:0]),
    .wdata (sample),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // scan decisions
  assign opening   = (cur > threshold) && !open;
  assign open_now  = open || opening;
  assign start_now = opening ? k_idx : start;
  assign close     = (cur < threshold) && (rdata < threshold) && open_now;

  assign valley = (win[0] > win[1]) && (win[1] > win[2]) &&
                  (win[2] < win[3]) && (win[3] < win[4]);

  always_comb begin
    seg_add = 1'b0;
    seg_wlo = lo;
    seg_whi = pb;
    case (state)
      S_SPLIT: begin
        if (int'(pb) - int'(pa) < MIN_SPLIT_LEN) begin
          seg_add = 1'b1;
          seg_wlo = pa;
        end
      end
      S_VAL_EVAL: begin
        seg_add = valley;
        seg_whi = wbase + IDX_W'(1);
      end
      S_SPLIT_TAIL: seg_add = 1'b1;
      default: seg_add = 1'b0;
    endcase
  end

  assign seg_room = (seg_kept < SEG_W'(MAX_CLUSTERS));

  cpcc_ram #(
    .DEPTH (MAX_CLUSTERS),
    .WIDTH (2 * IDX_W),
    .AW    (SADR_W)
  ) u_segs (
    .clk   (clk),
    .we    (seg_add && seg_room),
    .waddr (seg_kept[SADR_W-1:0]),
    .wdata ({seg_wlo, seg_whi}),
    .raddr (seg_i[SADR_W-1:0]),
    .rdata (seg_rdata)
  );

  // segment sums and centroid
  assign prod      = {{SAMPLE_W{1'b0}}, k_idx} * {{IDX_W{1'b0}}, rdata};
  assign numer     = {1'b0, wsum, 8'b0} + NUM_W'(esum >> 1);
  assign div_start = (state == S_DIV_START) && (esum != '0);
  assign e_ext     = {{ENERGY_W{1'b0}}, esum};
  assign last_seg  = ((seg_i + SEG_W'(1)) == seg_kept);

  cpcc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (numer),
    .den   (esum),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_x        = col_xy[2*COORD_W-1:COORD_W];
  assign out_y        = col_xy[COORD_W-1:0];
  assign overflow     = too_long || seg_over;
  assign last_cluster = last_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      threshold <= '0;
      count     <= '0;
      col_xy    <= '0;
      too_long  <= 1'b0;
      seg_kept  <= '0;
      seg_over  <= 1'b0;
      open      <= 1'b0;
      scan_done <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= pwdata[SAMPLE_W-1:0];
      end
      if (seg_add) begin
        if (seg_room) begin
          seg_kept <= seg_kept + SEG_W'(1);
        end else begin
          seg_over <= 1'b1;
        end
      end
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (count == '0) begin
              col_xy <= {col_x, col_y};
            end
            if (count < CNT_W'(COLUMN_DEPTH)) begin
              count <= count + CNT_W'(1);
            end else begin
              too_long <= 1'b1;
            end
            if (last) begin
              k         <= '0;
              open      <= 1'b0;
              scan_done <= 1'b0;
              state     <= S_SCAN_INIT;
            end
          end
        end
        S_SCAN_INIT: state <= S_SCAN_CUR;
        S_SCAN_CUR: begin
          cur   <= rdata;
          state <= S_SCAN_NEXT;
        end
        S_SCAN_NEXT: begin
          if ((k + CNT_W'(1)) < count) begin
            state <= S_SCAN_EVAL;
          end else begin
            state <= S_SCAN_END;
          end
        end
        S_SCAN_EVAL: begin
          cur <= rdata;
          k   <= k + CNT_W'(1);
          if (close) begin
            open  <= 1'b0;
            pa    <= start_now;
            pb    <= k_idx;
            state <= S_SPLIT;
          end else begin
            open  <= open_now;
            start <= start_now;
            state <= S_SCAN_NEXT;
          end
        end
        S_SCAN_END: begin
          scan_done <= 1'b1;
          if (open) begin
            open  <= 1'b0;
            pa    <= start;
            pb    <= IDX_W'(count - CNT_W'(1));
            state <= S_SPLIT;
          end else begin
            state <= S_SEG_START;
          end
        end
        S_SPLIT: begin
          if (int'(pb) - int'(pa) < MIN_SPLIT_LEN) begin
            state <= scan_done ? S_SEG_START : S_SCAN_NEXT;
          end else begin
            lo    <= pa;
            wbase <= pa;
            sk    <= CNT_W'(pa);
            fill  <= '0;
            state <= S_WIN_RD;
          end
        end
        S_WIN_RD: state <= S_WIN_GET;
        S_WIN_GET: begin
          win[0] <= win[1];
          win[1] <= win[2];
          win[2] <= win[3];
          win[3] <= win[4];
          win[4] <= rdata;
          sk     <= sk + CNT_W'(1);
          fill   <= fill + 3'd1;
          state  <= (fill == 3'd4) ? S_VAL_EVAL : S_WIN_RD;
        end
        S_VAL_EVAL: begin
          if (valley) begin
            lo <= wbase + IDX_W'(1);
          end
          wbase <= wbase + IDX_W'(1);
          if (sk <= CNT_W'(pb)) begin
            fill  <= 3'd4;
            state <= S_WIN_RD;
          end else begin
            state <= S_SPLIT_TAIL;
          end
        end
        S_SPLIT_TAIL: state <= scan_done ? S_SEG_START : S_SCAN_NEXT;
        S_SEG_START: begin
          seg_i <= '0;
          if (seg_kept == '0) begin
            count    <= '0;
            too_long <= 1'b0;
            seg_over <= 1'b0;
            state    <= S_LOAD;
          end else begin
            state <= S_SEG_RD;
          end
        end
        S_SEG_RD: state <= S_SEG_GET;
        S_SEG_GET: begin
          k      <= CNT_W'(seg_rdata[2*IDX_W-1:IDX_W]);
          seg_hi <= seg_rdata[IDX_W-1:0];
          esum   <= '0;
          wsum   <= '0;
          state  <= S_SUM_RD;
        end
        S_SUM_RD: begin
          state <= (k < CNT_W'(seg_hi)) ? S_SUM_ACC : S_DIV_START;
        end
        S_SUM_ACC: begin
          esum  <= esum + EACC_W'(rdata);
          wsum  <= wsum + WACC_W'(prod);
          k     <= k + CNT_W'(1);
          state <= S_SUM_RD;
        end
        S_DIV_START: begin
          cluster_energy <= (e_ext > EXT_W'(ENERGY_MAX)) ? ENERGY_MAX : e_ext[ENERGY_W-1:0];
          if (esum == '0) begin
            centroid <= '0;
            state    <= S_OUT;
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            centroid <= (div_quo > NUM_W'(CENTROID_MAX)) ? CENTROID_MAX
                                                          : div_quo[CENTROID_W-1:0];
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            seg_i <= seg_i + SEG_W'(1);
            if (last_seg) begin
              count    <= '0;
              too_long <= 1'b0;
              seg_kept <= '0;
              seg_over <= 1'b0;
              state    <= S_LOAD;
            end else begin
              state <= S_SEG_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_no_load: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_stall)
    else $error("sample accepted while a result is pending");

  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    seg_kept <= SEG_W'(MAX_CLUSTERS))
    else $error("segment count beyond limit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(COLUMN_DEPTH))
    else $error("sample count beyond store depth");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last_cluster) |=> !sample_stall)
    else $error("block not ready after final cluster transfer");
`endif

endmodule
`default_nettype wire
